// ===== hw/rtl/p1305_pkg.sv =====
package p1305_pkg;

   localparam int WORD_W   = 64;
   localparam int BLOCK_W  = 2 * WORD_W;
   localparam int BYTES_W  = 5;
   localparam int NUM_BYTES = BLOCK_W / 8;
   localparam int MSG_W    = BLOCK_W + 1;
   localparam int H_W      = 130;
   localparam int ACC_W    = H_W + 3;
   localparam int OPND_W   = H_W + 1;
   localparam int R_BITS   = 124;
   localparam int CNT_W    = $clog2(R_BITS + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [BLOCK_W-1:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_R_LOW  = 2'd0,
      CSR_R_HIGH = 2'd1,
      CSR_S_LOW  = 2'd2,
      CSR_S_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_FIN_GO,
      ST_FIN_WAIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      FIN_IDLE,
      FIN_FOLD,
      FIN_SUB,
      FIN_ADD
   } fin_step_type;

   typedef struct packed {
      logic busy;
      logic valid;
   } unit_stat_type;

   // Keep bytes below the count, put the 0x01 pad byte right after them;
   // a full block takes the 2^128 bit instead.
   function automatic logic [MSG_W-1:0] pad_block(input logic [BLOCK_W-1:0] blk,
                                                  input logic [BYTES_W-1:0] n);
      logic [MSG_W-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_BYTES; i++) begin
         if (BYTES_W'(i) < n) begin
            m[8*i +: 8] = blk[8*i +: 8];
         end else if (BYTES_W'(i) == n) begin
            m[8*i +: 8] = 8'h01;
         end
      end
      if (n >= BYTES_W'(NUM_BYTES)) begin
         m[MSG_W-1] = 1'b1;
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/p1305_if.sv =====
interface p1305_req_if import p1305_pkg::*;;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  block_low;
   logic [WORD_W-1:0]  block_high;
   logic [BYTES_W-1:0] block_bytes;
   logic               last_block;

   modport source (output valid, block_low, block_high, block_bytes, last_block,
                   input ready);
   modport sink (input valid, block_low, block_high, block_bytes, last_block,
                 output ready);
endinterface

interface p1305_rsp_if import p1305_pkg::*;;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] tag_low;
   logic [WORD_W-1:0] tag_high;

   modport source (output valid, tag_low, tag_high, input ready);
   modport sink (input valid, tag_low, tag_high, output ready);
endinterface

// ===== hw/rtl/poly1305_mac_core.sv =====
// Poly1305 tag engine, one 16-byte block per request.
// A block that absorbs bytes runs through the bit-serial multiplier, which walks the 124 bits
// of clamped r; no new request is accepted until the product is taken.
// A last block then adds the final reduction (fold, subtract, add s) and registers its tag
// once the response slot is free; a last block with no bytes goes straight to that reduction.
// Reset clears the key registers and the accumulator, and drops any pending tag.
module poly1305_mac_core import p1305_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   p1305_req_if.sink            req_bus,
   p1305_rsp_if.source          rsp_bus
);

   ctrl_state_type     state_ff, state_in;
   logic [BLOCK_W-1:0] r_key_ff, r_key_in;
   logic [BLOCK_W-1:0] s_key_ff, s_key_in;
   logic [ACC_W-1:0]   h_ff, h_in;
   logic [MSG_W-1:0]   m_ff, m_in;
   logic               absorb_ff, absorb_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] tag_ff, tag_in;

   logic               req_ready;
   logic               req_fire;
   logic               mul_start;
   logic               fin_start;
   logic               h_take;
   logic               out_load;
   logic               slot_free;
   logic [OPND_W-1:0]  mul_opnd;
   logic [BLOCK_W-1:0] r_clamped;
   logic [ACC_W-1:0]   mul_product;
   logic [BLOCK_W-1:0] fin_tag;
   unit_stat_type      mul_stat;
   unit_stat_type      fin_stat;

   assign req_fire  = req_bus.valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign r_clamped = r_key_ff & R_CLAMP;

   // fold h below 2^131 before adding the message block
   assign mul_opnd = {1'b0, h_ff[H_W-1:0]}
                   + OPND_W'({h_ff[ACC_W-1:H_W], 2'b00})
                   + OPND_W'(h_ff[ACC_W-1:H_W])
                   + OPND_W'(m_ff);

   always_comb begin
      r_key_in = r_key_ff;
      s_key_in = s_key_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_R_LOW:  r_key_in[WORD_W-1:0]       = csr_write_data;
            CSR_R_HIGH: r_key_in[BLOCK_W-1:WORD_W] = csr_write_data;
            CSR_S_LOW:  s_key_in[WORD_W-1:0]       = csr_write_data;
            CSR_S_HIGH: s_key_in[BLOCK_W-1:WORD_W] = csr_write_data;
            default:    r_key_in = r_key_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.block_bytes != '0) begin
                  state_in = ST_LOAD;
               end else if (req_bus.last_block) begin
                  state_in = ST_FIN_GO;
               end
            end
         end
         ST_LOAD: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_stat.valid) begin
               state_in = last_ff ? ST_FIN_GO : ST_IDLE;
            end
         end
         ST_FIN_GO: state_in = ST_FIN_WAIT;
         ST_FIN_WAIT: begin
            if (fin_stat.valid && slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      fin_start = 1'b0;
      h_take    = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_LOAD:     mul_start = 1'b1;
         ST_MUL:      h_take    = mul_stat.valid;
         ST_FIN_GO:   fin_start = 1'b1;
         ST_FIN_WAIT: out_load  = fin_stat.valid && slot_free;
         default:     req_ready = 1'b0;
      endcase
   end

   always_comb begin
      m_in      = m_ff;
      absorb_in = absorb_ff;
      last_in   = last_ff;
      if (req_fire) begin
         m_in      = pad_block({req_bus.block_high, req_bus.block_low}, req_bus.block_bytes);
         absorb_in = (req_bus.block_bytes != '0);
         last_in   = req_bus.last_block;
      end
   end

   always_comb begin
      h_in = h_ff;
      if (out_load) begin
         h_in = '0;
      end else if (h_take) begin
         h_in = mul_product;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      tag_in       = tag_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         tag_in       = fin_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         r_key_ff     <= '0;
         s_key_ff     <= '0;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_key_ff     <= r_key_in;
         s_key_ff     <= s_key_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      absorb_ff <= absorb_in;
      last_ff   <= last_in;
      tag_ff    <= tag_in;
   end

   p1305_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .opnd_a  (mul_opnd),
      .opnd_r  (r_clamped[R_BITS-1:0]),
      .stat    (mul_stat),
      .product (mul_product)
   );

   p1305_fin u_fin (
      .clock (clock),
      .reset (reset),
      .start (fin_start),
      .acc   (h_ff),
      .s_key (s_key_ff),
      .stat  (fin_stat),
      .tag   (fin_tag)
   );

   assign req_bus.ready    = req_ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.tag_low  = tag_ff[WORD_W-1:0];
   assign rsp_bus.tag_high = tag_ff[BLOCK_W-1:WORD_W];

   a_clear_after_tag: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (h_ff == '0))
      else $error("accumulator not cleared after tag");

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (!mul_stat.busy && absorb_ff))
      else $error("multiplier started while busy or without bytes");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!mul_stat.busy && !fin_stat.busy))
      else $error("request accepted while a unit is busy");

   a_take_next: assert property (@(posedge clock) disable iff (reset)
      h_take |=> (state_ff == ST_IDLE || state_ff == ST_FIN_GO))
      else $error("bad state after product capture");

endmodule

// ===== hw/rtl/p1305_mul.sv =====
module p1305_mul import p1305_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [OPND_W-1:0]  opnd_a,
   input  logic [R_BITS-1:0]  opnd_r,
   output unit_stat_type      stat,
   output logic [ACC_W-1:0]   product
);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [OPND_W-1:0] a_ff, a_in;
   logic [R_BITS-1:0] r_sr_ff, r_sr_in;
   logic [ACC_W-1:0]  p_ff, p_in;
   logic [ACC_W-1:0]  p_step;
   logic              busy;

   assign busy = (cnt_ff != '0);

   // p = 2p + bit*a, with bits above 2^130 folded back as 10 each
   assign p_step = {2'b00, p_ff[H_W-1:0], 1'b0}
                 + ACC_W'({p_ff[ACC_W-1:H_W], 3'b000})
                 + ACC_W'({p_ff[ACC_W-1:H_W], 1'b0})
                 + (r_sr_ff[R_BITS-1] ? ACC_W'(a_ff) : '0);

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      a_in     = a_ff;
      r_sr_in  = r_sr_ff;
      p_in     = p_ff;
      if (start) begin
         cnt_in   = CNT_W'(R_BITS);
         valid_in = 1'b0;
         a_in     = opnd_a;
         r_sr_in  = opnd_r;
         p_in     = '0;
      end else if (busy) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         r_sr_in = {r_sr_ff[R_BITS-2:0], 1'b0};
         p_in    = p_step;
         if (cnt_ff == CNT_W'(1)) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      r_sr_ff <= r_sr_in;
      p_ff    <= p_in;
   end

   assign stat.busy  = busy;
   assign stat.valid = valid_ff;
   assign product    = p_ff;

endmodule

// ===== hw/rtl/p1305_fin.sv =====
module p1305_fin import p1305_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ACC_W-1:0]   acc,
   input  logic [BLOCK_W-1:0] s_key,
   output unit_stat_type      stat,
   output logic [BLOCK_W-1:0] tag
);

   fin_step_type       step_ff, step_in;
   logic               valid_ff, valid_in;
   logic [OPND_W-1:0]  work_ff, work_in;
   logic [BLOCK_W-1:0] s_ff, s_in;
   logic [BLOCK_W-1:0] tag_ff, tag_in;
   logic [OPND_W-1:0]  fold_acc;
   logic [OPND_W-1:0]  fold_work;
   logic [OPND_W-1:0]  plus_five;

   assign fold_acc  = {1'b0, acc[H_W-1:0]}
                    + OPND_W'({acc[ACC_W-1:H_W], 2'b00})
                    + OPND_W'(acc[ACC_W-1:H_W]);
   assign fold_work = {1'b0, work_ff[H_W-1:0]}
                    + OPND_W'({work_ff[H_W], 2'b00})
                    + OPND_W'(work_ff[H_W]);
   // carry into bit 130 means the value is at least 2^130-5
   assign plus_five = work_ff + OPND_W'(5);

   always_comb begin
      step_in = step_ff;
      case (step_ff)
         FIN_IDLE: if (start) step_in = FIN_FOLD;
         FIN_FOLD: step_in = FIN_SUB;
         FIN_SUB:  step_in = FIN_ADD;
         FIN_ADD:  step_in = FIN_IDLE;
         default:  step_in = FIN_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      work_in  = work_ff;
      s_in     = s_ff;
      tag_in   = tag_ff;
      case (step_ff)
         FIN_IDLE: begin
            if (start) begin
               valid_in = 1'b0;
               work_in  = fold_acc;
               s_in     = s_key;
            end
         end
         FIN_FOLD: work_in = fold_work;
         FIN_SUB: begin
            if (plus_five[H_W]) begin
               work_in = {1'b0, plus_five[H_W-1:0]};
            end
         end
         FIN_ADD: begin
            tag_in   = work_ff[BLOCK_W-1:0] + s_ff;
            valid_in = 1'b1;
         end
         default: valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= FIN_IDLE;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      s_ff    <= s_in;
      tag_ff  <= tag_in;
   end

   assign stat.busy  = (step_ff != FIN_IDLE);
   assign stat.valid = valid_ff;
   assign tag        = tag_ff;

endmodule
